/* design/wavetable_morph_oscillator_top_defines.svh */
// Assertion macros for the wavetable morph oscillator checker.
// Included by the checker file; no other dependencies.
`ifndef WAVETABLE_MORPH_OSCILLATOR_TOP_DEFINES_SVH
`define WAVETABLE_MORPH_OSCILLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define WMO_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WMO_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/wmo_pkg.sv */
// Shared types, constants and the interpolation function of the oscillator.
// No dependencies.
package wmo_pkg;

   localparam int FRAME_COUNT_DEF = 64;
   localparam int FRAME_SIZE_DEF  = 256;

   localparam int OP_W    = 1;
   localparam int LADDR_W = 14;
   localparam int SMP_W   = 16;
   localparam int LEVEL_W = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [OP_W-1:0] OP_TICK = 1'b0;
   localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_INC  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TABLE_POS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VOICE_GAIN = 3'd4;

   localparam logic [1:0] RD_A0 = 2'd0;
   localparam logic [1:0] RD_A1 = 2'd1;
   localparam logic [1:0] RD_B0 = 2'd2;
   localparam logic [1:0] RD_B1 = 2'd3;

   localparam logic [1:0] LERP_F0  = 2'd0;
   localparam logic [1:0] LERP_F1  = 2'd1;
   localparam logic [1:0] LERP_MIX = 2'd2;

   typedef struct packed {
      logic        enable;
      logic [31:0] phase_increment;
      logic [15:0] table_position;
      logic [15:0] mod_depth;
      logic [15:0] voice_gain;
   } cfg_type;

   typedef struct packed {
      logic       load_wr;
      logic       tick_start;
      logic       zero;
      logic       idx;
      logic       base;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap;
      logic       lerp_en;
      logic [1:0] lerp_sel;
      logic       mul1;
      logic       mul2;
      logic       sat;
      logic       out_load;
   } cmd_type;

   // a + round((b - a) * frac / 65536), half toward plus infinity
   function automatic logic signed [15:0] lerp16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic [15:0] frac);
      logic signed [16:0] diff;
      logic signed [34:0] prod;
      logic signed [18:0] step;
      logic signed [17:0] sum;
      diff = $signed({b[15], b}) - $signed({a[15], a});
      prod = 35'(diff) * 35'($signed({1'b0, frac})) + 35'sd32768;
      step = 19'(prod >>> 16);
      sum  = 18'(a) + 18'(step);
      return sum[15:0];
   endfunction

endpackage

/* design/wmo_req_if.sv */
// Request channel interface: valid/ready plus the request payload.
// Depends on wmo_pkg.
interface wmo_req_if;
   import wmo_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic [LADDR_W-1:0]        load_address;
   logic signed [SMP_W-1:0]   load_value;
   logic [LEVEL_W-1:0]        envelope_level;

   modport source (output valid, operation, load_address, load_value, envelope_level,
                   input ready);
   modport sink   (input valid, operation, load_address, load_value, envelope_level,
                   output ready);
endinterface

/* design/wmo_rsp_if.sv */
// Response channel interface: valid/ready plus the output sample.
// Depends on wmo_pkg.
interface wmo_rsp_if;
   import wmo_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

/* design/wmo_csr.sv */
// APB-style register file holding the oscillator configuration.
// Depends on wmo_pkg.
module wmo_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wmo_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wmo_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wmo_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output wmo_pkg::cfg_type                cfg
);
   import wmo_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   wr;
   logic [REG_IDX_W-1:0]   idx;

   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_ENABLE:     cfg_in.enable          = csr_pwdata[0];
            REG_PHASE_INC:  cfg_in.phase_increment = csr_pwdata;
            REG_TABLE_POS:  cfg_in.table_position  = csr_pwdata[15:0];
            REG_MOD_DEPTH:  cfg_in.mod_depth       = csr_pwdata[15:0];
            REG_VOICE_GAIN: cfg_in.voice_gain      = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ENABLE:     csr_prdata = {31'd0, cfg_ff.enable};
         REG_PHASE_INC:  csr_prdata = cfg_ff.phase_increment;
         REG_TABLE_POS:  csr_prdata = {16'd0, cfg_ff.table_position};
         REG_MOD_DEPTH:  csr_prdata = {16'd0, cfg_ff.mod_depth};
         REG_VOICE_GAIN: csr_prdata = {16'd0, cfg_ff.voice_gain};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* design/wmo_ctrl.sv */
// Sequencer for the oscillator: handshakes and datapath commands.
// Depends on wmo_pkg.
module wmo_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [wmo_pkg::OP_W-1:0] req_operation,
   output logic                     req_ready,
   input  logic                     enable,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output wmo_pkg::cmd_type         cmd
);
   import wmo_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_IDX  = 4'd1;
   localparam logic [3:0] ST_BASE = 4'd2;
   localparam logic [3:0] ST_RD0  = 4'd3;
   localparam logic [3:0] ST_RD1  = 4'd4;
   localparam logic [3:0] ST_RD2  = 4'd5;
   localparam logic [3:0] ST_RD3  = 4'd6;
   localparam logic [3:0] ST_CAP  = 4'd7;
   localparam logic [3:0] ST_LRPA = 4'd8;
   localparam logic [3:0] ST_LRPB = 4'd9;
   localparam logic [3:0] ST_LRPC = 4'd10;
   localparam logic [3:0] ST_MUL1 = 4'd11;
   localparam logic [3:0] ST_MUL2 = 4'd12;
   localparam logic [3:0] ST_SAT  = 4'd13;
   localparam logic [3:0] ST_OUT  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else if (enable) begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_IDX;
               end else begin
                  cmd.zero = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_IDX: begin
            cmd.idx  = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_A0;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_A1;
            cmd.cap    = 1'b1;
            state_in   = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B0;
            cmd.cap    = 1'b1;
            state_in   = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B1;
            cmd.cap    = 1'b1;
            state_in   = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = ST_LRPA;
         end
         ST_LRPA: begin
            cmd.lerp_en  = 1'b1;
            cmd.lerp_sel = LERP_F0;
            state_in     = ST_LRPB;
         end
         ST_LRPB: begin
            cmd.lerp_en  = 1'b1;
            cmd.lerp_sel = LERP_F1;
            state_in     = ST_LRPC;
         end
         ST_LRPC: begin
            cmd.lerp_en  = 1'b1;
            cmd.lerp_sel = LERP_MIX;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* design/wmo_dp.sv */
// Datapath: wave table memory, phase accumulator, index math,
// shared interpolator, gain multipliers and output register. Depends on wmo_pkg.
module wmo_dp #(
   parameter int FRAME_COUNT = wmo_pkg::FRAME_COUNT_DEF,
   parameter int FRAME_SIZE  = wmo_pkg::FRAME_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wmo_pkg::cmd_type                   cmd,
   input  wmo_pkg::cfg_type                   cfg,
   input  logic [wmo_pkg::LADDR_W-1:0]        req_load_address,
   input  logic signed [wmo_pkg::SMP_W-1:0]   req_load_value,
   input  logic [wmo_pkg::LEVEL_W-1:0]        req_envelope_level,
   output logic signed [wmo_pkg::SMP_W-1:0]   rsp_sample_out
);
   import wmo_pkg::*;

   localparam int FRAME_W  = $clog2(FRAME_COUNT);
   localparam int SAMPLE_W = $clog2(FRAME_SIZE);
   localparam int DEPTH    = FRAME_COUNT * FRAME_SIZE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SPROD_W  = 33 + SAMPLE_W;
   localparam int FPROD_W  = 17 + FRAME_W;

   localparam logic signed [18:0] SAT_HI = 19'sd32767;
   localparam logic signed [18:0] SAT_LO = -19'sd32768;

   logic signed [15:0] mem [DEPTH];

   logic [31:0]          phase_ff, phase_in;
   logic [15:0]          env_ff;
   logic [FRAME_W-1:0]   frame0_ff, frame1_ff, frame0_in, frame1_in;
   logic [15:0]          ffrac_ff, ffrac_in;
   logic [SAMPLE_W-1:0]  s0_ff, s1_ff, s0_in, s1_in;
   logic [15:0]          sfrac_ff, sfrac_in;
   logic [ADDR_W-1:0]    base0_ff, base1_ff, base0_in, base1_in;
   logic signed [15:0]   rdata_ff;
   logic signed [15:0]   taps_ff [4];
   logic signed [15:0]   f0_ff, f1_ff, smp_ff;
   logic signed [32:0]   prod1_ff, prod1_in;
   logic signed [49:0]   prod2_ff, prod2_in;
   logic signed [15:0]   result_ff, result_in;
   logic signed [15:0]   sample_out_ff;

   logic [16:0]          pos_sum, pos;
   logic [FPROD_W-1:0]   fprod;
   logic [SPROD_W-1:0]   sprod;
   logic [ADDR_W-1:0]    rd_addr, mem_addr;
   logic                 load_ok;
   logic signed [15:0]   lerp_a, lerp_b, lerp_q;
   logic [15:0]          lerp_f;
   logic signed [50:0]   rsum;
   logic signed [18:0]   rshift;

   // index math
   always_comb begin
      pos_sum   = 17'(cfg.table_position) + 17'(cfg.mod_depth[15:1]);
      pos       = (pos_sum > 17'd65536) ? 17'd65536 : pos_sum;
      fprod     = FPROD_W'(pos) * FPROD_W'(FRAME_COUNT - 1);
      frame0_in = fprod[16 +: FRAME_W];
      ffrac_in  = fprod[15:0];
      frame1_in = (frame0_in == FRAME_W'(FRAME_COUNT - 1)) ? frame0_in
                                                            : frame0_in + FRAME_W'(1);
      sprod     = SPROD_W'(phase_ff) * SPROD_W'(FRAME_SIZE);
      s0_in     = sprod[32 +: SAMPLE_W];
      s1_in     = (s0_in == SAMPLE_W'(FRAME_SIZE - 1)) ? '0 : s0_in + SAMPLE_W'(1);
      sfrac_in  = sprod[31:16];
      base0_in  = ADDR_W'(frame0_ff) * ADDR_W'(FRAME_SIZE);
      base1_in  = ADDR_W'(frame1_ff) * ADDR_W'(FRAME_SIZE);
   end

   // single-port table access
   always_comb begin
      case (cmd.rd_sel)
         RD_A0:   rd_addr = base0_ff + ADDR_W'(s0_ff);
         RD_A1:   rd_addr = base0_ff + ADDR_W'(s1_ff);
         RD_B0:   rd_addr = base1_ff + ADDR_W'(s0_ff);
         RD_B1:   rd_addr = base1_ff + ADDR_W'(s1_ff);
         default: rd_addr = base0_ff;
      endcase
      load_ok  = ({18'd0, req_load_address} < 32'(DEPTH));
      mem_addr = cmd.load_wr ? ADDR_W'(req_load_address) : rd_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) begin
         mem[mem_addr] <= req_load_value;
      end else if (cmd.rd_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // shared interpolator
   always_comb begin
      case (cmd.lerp_sel)
         LERP_F0: begin
            lerp_a = taps_ff[0];
            lerp_b = taps_ff[1];
            lerp_f = sfrac_ff;
         end
         LERP_F1: begin
            lerp_a = taps_ff[2];
            lerp_b = taps_ff[3];
            lerp_f = sfrac_ff;
         end
         LERP_MIX: begin
            lerp_a = f0_ff;
            lerp_b = f1_ff;
            lerp_f = ffrac_ff;
         end
         default: begin
            lerp_a = f0_ff;
            lerp_b = f1_ff;
            lerp_f = ffrac_ff;
         end
      endcase
      lerp_q = lerp16(lerp_a, lerp_b, lerp_f);
   end

   // gain, rounding, saturation, phase advance
   always_comb begin
      prod1_in = 33'(smp_ff) * 33'($signed({1'b0, env_ff}));
      prod2_in = 50'(prod1_ff) * 50'($signed({1'b0, cfg.voice_gain}));
      rsum     = 51'(prod2_ff) + 51'sd2147483648;
      rshift   = 19'(rsum >>> 32);
      if (rshift > SAT_HI) begin
         result_in = 16'sh7fff;
      end else if (rshift < SAT_LO) begin
         result_in = 16'sh8000;
      end else begin
         result_in = rshift[15:0];
      end
      phase_in = phase_ff + cfg.phase_increment;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.sat) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         env_ff <= req_envelope_level;
      end
      if (cmd.idx) begin
         frame0_ff <= frame0_in;
         frame1_ff <= frame1_in;
         ffrac_ff  <= ffrac_in;
         s0_ff     <= s0_in;
         s1_ff     <= s1_in;
         sfrac_ff  <= sfrac_in;
      end
      if (cmd.base) begin
         base0_ff <= base0_in;
         base1_ff <= base1_in;
      end
      if (cmd.cap) begin
         taps_ff[0] <= taps_ff[1];
         taps_ff[1] <= taps_ff[2];
         taps_ff[2] <= taps_ff[3];
         taps_ff[3] <= rdata_ff;
      end
      if (cmd.lerp_en) begin
         case (cmd.lerp_sel)
            LERP_F0:  f0_ff  <= lerp_q;
            LERP_F1:  f1_ff  <= lerp_q;
            LERP_MIX: smp_ff <= lerp_q;
            default:  smp_ff <= lerp_q;
         endcase
      end
      if (cmd.mul1) begin
         prod1_ff <= prod1_in;
      end
      if (cmd.mul2) begin
         prod2_ff <= prod2_in;
      end
      if (cmd.zero) begin
         result_ff <= '0;
      end else if (cmd.sat) begin
         result_ff <= result_in;
      end
      if (cmd.out_load) begin
         sample_out_ff <= result_ff;
      end
   end

   assign rsp_sample_out = sample_out_ff;
endmodule

/* design/wavetable_morph_oscillator_top.sv */
// Top level of the wavetable morph oscillator: register file, sequencer, datapath.
// Depends on wmo_pkg, wmo_req_if, wmo_rsp_if, wmo_csr, wmo_ctrl, wmo_dp.
//
//   port      direction  handshake        carries
//   req_if    in         valid/ready      operation, load_address, load_value, envelope_level
//   rsp_if    out        valid/ready      sample_out
//   csr_*     in         APB write/read   enable, phase_increment, table_position,
//                                         mod_depth, voice_gain
//
// A load is written at its accepting edge; the block is ready again in the next cycle.
// A tick keeps the block busy through accept, index math, frame base, four reads from the
// single-port table, tap capture, three interpolator passes, two gain multiplies, saturation
// and the output step, after which the result loads into the output register. A disabled
// tick clears the result and goes straight to the output step. The output step stalls while
// the previous result is still unaccepted; a new request is taken while a result waits.
// Synchronous active-high reset clears sequencer, CSR registers and phase, not the table.
module wavetable_morph_oscillator_top #(
   parameter int FRAME_COUNT = wmo_pkg::FRAME_COUNT_DEF,
   parameter int FRAME_SIZE  = wmo_pkg::FRAME_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   wmo_req_if.sink                         req_if,
   wmo_rsp_if.source                       rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wmo_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wmo_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wmo_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import wmo_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   wmo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wmo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (req_if.ready),
      .enable        (cfg.enable),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .cmd           (cmd)
   );

   wmo_dp #(
      .FRAME_COUNT (FRAME_COUNT),
      .FRAME_SIZE  (FRAME_SIZE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_load_address   (req_if.load_address),
      .req_load_value     (req_if.load_value),
      .req_envelope_level (req_if.envelope_level),
      .rsp_sample_out     (rsp_if.sample_out)
   );
endmodule

/* design/wmo_checker.sv */
// Port-level assertion checker for the oscillator, bound to the top level.
// Depends on wmo_pkg and wavetable_morph_oscillator_top_defines.svh.
`include "wavetable_morph_oscillator_top_defines.svh"

module wmo_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [wmo_pkg::OP_W-1:0]          req_operation,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [wmo_pkg::SMP_W-1:0]  rsp_sample_out,
   input logic                              csr_pready
);
   import wmo_pkg::*;

   // a tick request keeps the block busy for at least the next cycle
   `WMO_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && req_operation == OP_TICK, !req_ready, "tick request did not occupy the block")
   // a table load leaves the block ready again in the next cycle
   `WMO_ASSERT_NEXT(a_load_single, clock, reset, req_valid && req_ready && req_operation == OP_LOAD, req_ready, "table load did not complete in one cycle")
   `WMO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out), "stalled response changed")
   `WMO_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_ready, "block not idle after reset")
   `WMO_ASSERT_IMPLY(a_pready, clock, reset, 1'b1, csr_pready, "register port stalled")
endmodule

bind wavetable_morph_oscillator_top wmo_checker u_wmo_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_operation  (req_if.operation),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_sample_out (rsp_if.sample_out),
   .csr_pready     (csr_pready)
);
